// File: sv/pwlc_pkg.sv
`default_nettype none
package pwlc_pkg;

  localparam int MAX_POINTS_DEF  = 10;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int COUNT_WRAP      = 10000;
  localparam int RUN_W           = 14;
  localparam int IDX_FIELD_W     = 4;
  localparam int CNT_FIELD_W     = 4;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  typedef enum logic [0:0] {
    REG_POINT_COUNT = 1'b0,
    REG_ENABLE      = 1'b1
  } reg_idx_t;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

endpackage
`default_nettype wire

// File: sv/pwlc_ram.sv
`default_nettype none
module pwlc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/piecewise_linear_curve.sv
// channel  direction  handshake          payload
// in       input      in_valid/in_ready  operation, point_index, point_u, point_v, sample_u
// out      output     out_valid/out_ready value_out, enable_out, run_count
// cfg      input      APB psel/penable   point_count (0x0), enable (0x4)
//
// A checkpoint write is taken in idle. An evaluation runs accept, a table scan through the
// one-read-port memory, setup, multiply, 2*VALUE_WIDTH restoring division steps, fix-up
// and output load; a match or a sample beyond the end points skips from setup to output
// load, disabled or n < 2 from accept. A full output register stalls the output load.
// Synchronous reset clears the table through per-entry valid bits, held value and counter.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module piecewise_linear_curve
  import pwlc_pkg::*;
#(
  parameter int MAX_POINTS  = pwlc_pkg::MAX_POINTS_DEF,
  parameter int VALUE_WIDTH = pwlc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_operation,
  input  wire logic [pwlc_pkg::IDX_FIELD_W-1:0]      in_point_index,
  input  wire logic signed [VALUE_WIDTH-1:0]         in_point_u,
  input  wire logic signed [VALUE_WIDTH-1:0]         in_point_v,
  input  wire logic signed [VALUE_WIDTH-1:0]         in_sample_u,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [VALUE_WIDTH-1:0]              out_value_out,
  output logic                                       out_enable_out,
  output logic [pwlc_pkg::RUN_W-1:0]                 out_run_count,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [pwlc_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [pwlc_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [pwlc_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                       pready
);

  localparam int VW = VALUE_WIDTH;
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * VW;
  localparam int DW = $clog2(PW);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CALC, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0]          cnt_r;
  logic                   en_r;
  logic [MAX_POINTS-1:0]  valid_r;
  logic signed [VW-1:0]   s_r;
  logic [CW-1:0]          n_r;
  logic [CW-1:0]          iss_r;
  logic                   rd_pend_r;
  logic                   rd_vld_r;
  logic                   eq_f_r, lo_f_r, hi_f_r;
  logic signed [VW-1:0]   eq_v_r, lo_u_r, lo_v_r, hi_u_r, hi_v_r;
  logic [VW-1:0]          mag_r, du_r, span_r, rem_r;
  logic                   neg_r;
  logic [PW-1:0]          p_r;
  logic [DW-1:0]          dcnt_r;
  logic signed [VW-1:0]   res_r, held_r, out_value_r;
  logic                   eno_r, out_valid_r, out_eno_r;
  logic [RUN_W-1:0]       run_r, out_run_r, run_nxt;

  logic                   in_acc, ram_we, cfg_wr, issue;
  logic [AW-1:0]          ram_raddr;
  logic [2*VW-1:0]        ram_wdata, ram_rdata;
  logic signed [VW-1:0]   e_u, e_v;
  logic signed [VW:0]     dv, du_ext, res_ext;
  logic [VW:0]            rem_sh;
  logic                   div_ge;
  logic [VW-1:0]          rem_nxt;
  logic [CNT_FIELD_W-1:0] wcnt;
  reg_idx_t               widx, ridx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_operation == OP_WRITE) && (int'(in_point_index) < MAX_POINTS);
  assign ram_wdata = {in_point_u, in_point_v};
  assign issue     = (state_r == S_SCAN) && (iss_r < n_r);
  assign ram_raddr = iss_r[AW-1:0];

  pwlc_ram #(.WIDTH(2 * VW), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_point_index)),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign e_u = rd_vld_r ? $signed(ram_rdata[2*VW-1:VW]) : '0;
  assign e_v = rd_vld_r ? $signed(ram_rdata[VW-1:0]) : '0;

  assign dv      = {hi_v_r[VW-1], hi_v_r} - {lo_v_r[VW-1], lo_v_r};
  assign du_ext  = {s_r[VW-1], s_r} - {lo_u_r[VW-1], lo_u_r};
  assign rem_sh  = {rem_r, p_r[PW-1]};
  assign div_ge  = rem_sh >= {1'b0, span_r};
  assign rem_nxt = div_ge ? VW'(rem_sh - {1'b0, span_r}) : rem_sh[VW-1:0];
  assign res_ext = neg_r ? ({s_r[VW-1] & 1'b0, lo_v_r} - {1'b0, p_r[VW-1:0]})
                         : ({1'b0, lo_v_r} + {1'b0, p_r[VW-1:0]});

  assign run_nxt = (int'(run_r) == COUNT_WRAP - 1) ? '0 : RUN_W'(run_r + 1'b1);

  assign cfg_wr = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[2]);
  assign ridx   = reg_idx_t'(paddr[2]);
  assign wcnt   = pwdata[CNT_FIELD_W-1:0];
  assign pready = 1'b1;

  always_comb begin
    case (ridx)
      REG_POINT_COUNT: prdata = APB_DATA_W'(cnt_r);
      REG_ENABLE:      prdata = APB_DATA_W'(en_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      en_r        <= 1'b1;
      valid_r     <= '0;
      held_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (cfg_wr && pready) begin
        case (widx)
          REG_POINT_COUNT: cnt_r <= (int'(wcnt) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(wcnt);
          REG_ENABLE:      en_r  <= pwdata[0];
          default:         ;
        endcase
      end
      if (ram_we) begin
        valid_r[AW'(in_point_index)] <= 1'b1;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= issue;
      rd_vld_r  <= valid_r[ram_raddr];
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_operation == OP_EVAL) begin
            s_r    <= in_sample_u;
            n_r    <= cnt_r;
            iss_r  <= '0;
            eq_f_r <= 1'b0;
            lo_f_r <= 1'b0;
            hi_f_r <= 1'b0;
            if (en_r && cnt_r >= CW'(2)) begin
              eno_r   <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              eno_r   <= 1'b0;
              res_r   <= held_r;
              state_r <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            iss_r <= iss_r + 1'b1;
          end
          if (rd_pend_r) begin
            if (e_u == s_r) begin
              if (!eq_f_r) begin
                eq_f_r <= 1'b1;
                eq_v_r <= e_v;
              end
            end else if (e_u < s_r) begin
              if (!lo_f_r || e_u >= lo_u_r) begin
                lo_f_r <= 1'b1;
                lo_u_r <= e_u;
                lo_v_r <= e_v;
              end
            end else begin
              if (!hi_f_r || e_u < hi_u_r) begin
                hi_f_r <= 1'b1;
                hi_u_r <= e_u;
                hi_v_r <= e_v;
              end
            end
          end
          if (!issue && !rd_pend_r) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          mag_r  <= dv[VW] ? VW'(-dv) : dv[VW-1:0];
          neg_r  <= dv[VW];
          du_r   <= du_ext[VW-1:0];
          span_r <= VW'(hi_u_r - lo_u_r);
          if (eq_f_r) begin
            res_r   <= eq_v_r;
            state_r <= S_DONE;
          end else if (!lo_f_r) begin
            res_r   <= hi_v_r;
            state_r <= S_DONE;
          end else if (!hi_f_r) begin
            res_r   <= lo_v_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          p_r     <= PW'(mag_r * du_r);
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          p_r    <= {p_r[PW-2:0], div_ge};
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == DW'(PW - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r   <= res_ext[VW-1:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= res_r;
            out_eno_r   <= eno_r;
            out_run_r   <= run_nxt;
            run_r       <= run_nxt;
            held_r      <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value_out  = out_value_r;
  assign out_enable_out = out_eno_r;
  assign out_run_count  = out_run_r;

  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (int'(out_run_r) < COUNT_WRAP))
    else $error("run count out of range");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("table written during evaluation");

  a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (p_r[VW-1:0] <= mag_r) && (p_r[PW-1:VW] == '0))
    else $error("quotient exceeds ordinate span");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (int'(dcnt_r) < PW))
    else $error("division step count overrun");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_r <= n_r) && (n_r >= CW'(2)))
    else $error("scan index past point count");

endmodule
`default_nettype wire
